// File: sv/dependency_task_budget_scheduler_core_defines.svh
// Assertion macros for the task scheduler.
`ifndef DEPENDENCY_TASK_BUDGET_SCHEDULER_CORE_DEFINES_SVH
`define DEPENDENCY_TASK_BUDGET_SCHEDULER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define DTBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define DTBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dtbs_pkg.sv
`default_nettype none
package dtbs_pkg;
  localparam int MaxTasks  = 16;
  localparam int IdBits    = 4;
  localparam int CntBits   = 5;
  localparam int OwnerBits = 8;
  localparam int TimeBits  = 32;

  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_ACTIVATE = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] PH_PENDING = 2'd0;
  localparam logic [1:0] PH_ACTIVE  = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // one table entry as stored in the task memory
  typedef struct packed {
    logic [OwnerBits-1:0] owner;
    logic [TimeBits-1:0]  need;
    logic [15:0]          prereqs;
  } entry_t;
endpackage
`default_nettype wire

// File: sv/dependency_task_budget_scheduler_core.sv
// Channel | Dir | Payload
// in_     | in  | tdata {prereq_mask, time_amount, owner}, tuser func
// out_    | out | tdata {time_spent, activated_count, task_id, status}, tuser task_valid, tlast
// Add and func 3 results are registered at the accepting edge.
// Activate and advance walk every stored task through the single entry memory
// read port, each entry in a read state and then an evaluate state; advance
// stops walking once its budget is used up.
// Reset clears the task count and the completion bits; no clearing pass.
// A result waits in the output register; the walk holds while it is full.
`default_nettype none
module dependency_task_budget_scheduler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,  // owner[7:0], time_amount[39:8], prereq_mask[55:40]
  input  wire logic [1:0]  in_tuser,  // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // status[1:0], task_id[5:2], activated_count[10:6],
                                      // time_spent[42:11], zero fill
  output logic             out_tuser, // task_valid
  output logic             out_tlast
);
  import dtbs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  // entry memory holds owner, remaining need and prereqs; phase in flops
  entry_t mem [MaxTasks];
  entry_t rd_r;
  logic   wr_en;
  logic [IdBits-1:0] wr_addr, rd_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  logic [2:0]  state_r, state_nxt;
  logic [CntBits-1:0] count_r, count_nxt;
  logic [1:0]  ph_r [MaxTasks];
  logic [MaxTasks-1:0] done_r; // snapshot-free completion view
  logic [1:0]  func_r, func_nxt;
  logic [OwnerBits-1:0] own_r, own_nxt;
  logic [TimeBits-1:0]  left_r, left_nxt, spent_r, spent_nxt;
  logic [CntBits-1:0]   idx_r, idx_nxt, act_r, act_nxt;
  logic ph_we;
  logic [1:0] ph_wv;
  logic        ov_r, ov_nxt;
  logic [47:0] od_r, od_nxt;
  logic        ou_r, ou_nxt, ol_r, ol_nxt;

  logic [IdBits-1:0] cur;
  logic prq_ok, busy_out;
  assign cur = idx_r[IdBits-1:0];
  assign busy_out = ov_r && !out_tready;
  assign in_tready = (state_r == S_IDLE) && !busy_out;

  // prerequisite check against completion bits of valid ids
  always_comb begin
    prq_ok = 1'b1;
    for (int b = 0; b < MaxTasks; b++) begin
      if (rd_r.prereqs[b] && (b >= int'(count_r) || !done_r[b])) prq_ok = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;  count_nxt = count_r; func_nxt = func_r; own_nxt = own_r;
    left_nxt = left_r;    spent_nxt = spent_r; idx_nxt = idx_r;   act_nxt = act_r;
    ov_nxt = ov_r && !out_tready; od_nxt = od_r; ou_nxt = ou_r; ol_nxt = ol_r;
    wr_en = 1'b0; wr_addr = count_r[IdBits-1:0]; wr_data = '0;
    rd_addr = cur; ph_we = 1'b0; ph_wv = PH_PENDING;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          func_nxt = in_tuser; own_nxt = in_tdata[7:0]; left_nxt = in_tdata[39:8];
          spent_nxt = '0; idx_nxt = '0; act_nxt = '0;
          ov_nxt = 1'b1; ou_nxt = 1'b0; ol_nxt = 1'b1; od_nxt = '0;
          case (in_tuser)
            FUNC_ADD: begin
              if (in_tdata[39:8] == '0) begin
                od_nxt[1:0] = ST_ZERO;
              end else if (count_r >= CntBits'(MaxTasks)) begin
                od_nxt[1:0] = ST_FULL;
              end else begin
                wr_en = 1'b1;
                wr_data.owner = in_tdata[7:0];
                wr_data.need = in_tdata[39:8];
                wr_data.prereqs = in_tdata[55:40];
                ph_we = 1'b1; ph_wv = PH_PENDING;
                od_nxt[5:2] = count_r[IdBits-1:0];
                ou_nxt = 1'b1;
                count_nxt = count_r + CntBits'(1);
              end
            end
            FUNC_ACTIVATE, FUNC_ADVANCE: begin
              ov_nxt = 1'b0; state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (idx_r >= count_r || (func_r == FUNC_ADVANCE && left_r == '0)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!busy_out) begin
          state_nxt = S_READ;
          idx_nxt = idx_r + CntBits'(1);
          rd_addr = cur;
          if (func_r == FUNC_ACTIVATE) begin
            if (ph_r[cur] == PH_PENDING && prq_ok) begin
              ph_we = 1'b1; ph_wv = PH_ACTIVE; act_nxt = act_r + CntBits'(1);
            end
          end else if (ph_r[cur] == PH_ACTIVE && rd_r.owner == own_r) begin
            wr_addr = cur; wr_data = rd_r;
            if (left_r >= rd_r.need) begin
              ph_we = 1'b1; ph_wv = PH_DONE;
              spent_nxt = spent_r + rd_r.need;
              left_nxt = left_r - rd_r.need;
              wr_data.need = '0; wr_en = 1'b1;
              ov_nxt = 1'b1; ol_nxt = 1'b0; ou_nxt = 1'b1; od_nxt = '0;
              od_nxt[5:2] = cur;
            end else begin
              spent_nxt = spent_r + left_r; left_nxt = '0;
              wr_data.need = rd_r.need - left_r; wr_en = 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        if (!busy_out) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; ou_nxt = 1'b0; od_nxt = '0;
          od_nxt[10:6] = act_r; od_nxt[42:11] = spent_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_READ) rd_addr = cur;
  end

  function automatic logic [IdBits-1:0] wr_addr_ph();
    return (state_r == S_IDLE) ? count_r[IdBits-1:0] : cur;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ov_r <= 1'b0; done_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; ov_r <= ov_nxt;
      if (ph_we) done_r[wr_addr_ph()] <= (ph_wv == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_r[wr_addr_ph()] <= ph_wv;
    func_r <= func_nxt; own_r <= own_nxt; left_r <= left_nxt; spent_r <= spent_nxt;
    idx_r <= idx_nxt; act_r <= act_nxt; od_r <= od_nxt; ou_r <= ou_nxt; ol_r <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

`include "dependency_task_budget_scheduler_core_defines.svh"
  `DTBS_ASSERT_IMP(a_ready_idle, in_tready, state_r == S_IDLE, "ready outside idle")
  `DTBS_ASSERT_IMP(a_cnt_max, 1'b1, count_r <= CntBits'(MaxTasks), "task count overflow")
  `DTBS_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
endmodule
`default_nettype wire
